[sv/wmf_pkg.sv]
// Shared types and constants for the window max-min edge filter.
// No dependencies; the top level, front end and back end import this package.
`default_nettype none

package wmf_pkg;

    // Pixel word: three 8-bit channels, chan0 in the low byte
    localparam int CHAN_W = 8;
    localparam int N_CHAN = 3;
    localparam int PIX_W  = CHAN_W * N_CHAN;

    // Configuration register
    localparam int          CFG_W           = 12;
    localparam logic [11:0] FRAME_WIDTH_RST = 12'd640;

    // Window size and smallest usable row width
    localparam int KSIZE = 3;

    // Default image limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Queue depths (powers of two)
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

`default_nettype wire

[sv/window_max_min_edge_filter.sv]
// Top level of the 3x3 window max-min edge filter.
// Depends on wmf_pkg, wmf_front, wmf_fifo and wmf_back.
// Usage:
//   Input queue: drive one pixel (i_chan0..2, i_start_of_frame) with push;
//   it is taken on a clock edge where push is high and full is low.
//   Output queue: while empty is low the oldest result sits on o_edge0..2,
//   o_out_row and o_out_col; pop high at a clock edge takes it.
//   A result for centre (row-1, col-1) follows the pixel at (row, col) when
//   both are at least one; the last row and column give no result.
//   Configuration: i_cfg_we writes i_cfg_wdata to frame_width (clamped to
//   3..MAX_WIDTH in use); write it only while the block is idle.
// Timing:
//   A pixel crosses the middle queue, compute stage, result stage and result
//   queue before empty falls. Rate: one pixel per cycle unless back-pressure
//   stalls, set by one line store write and read port, each used once a pixel.
// Reset and stalls:
//   Reset empties both queues, zeroes counters and window and sets the
//   width to 640; the line store is not cleared, rows above the image are
//   masked. When pop stays low the 8-entry result queue fills, the back end
//   stops taking work and full rises once the 4-entry middle queue is full.
`default_nettype none

module window_max_min_edge_filter #(
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [wmf_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [wmf_pkg::CHAN_W-1:0]  i_chan0,
    input  wire logic [wmf_pkg::CHAN_W-1:0]  i_chan1,
    input  wire logic [wmf_pkg::CHAN_W-1:0]  i_chan2,
    input  wire logic                        i_start_of_frame,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge0,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge1,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge2,
    output logic [$clog2(MAX_HEIGHT)-1:0]    o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_out_col
);

    import wmf_pkg::*;

    localparam int ITEM_W = PIX_W + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH);

    logic              accept;
    t_pix              pix;
    logic [ITEM_W-1:0] front_item;
    logic [ITEM_W-1:0] mid_item;
    logic              mid_empty;
    logic              mid_pop;

    assign accept = push & ~full;
    assign pix    = {i_chan2, i_chan1, i_chan0};

    // Tag each request with its raster position
    wmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_sof       (i_start_of_frame),
        .i_pix       (pix),
        .o_item      (front_item)
    );

    // Decouple front and back
    wmf_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_full  (full),
        .o_empty (mid_empty),
        .o_count ()
    );

    // Filter and queue results
    wmf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (~mid_empty),
        .i_item       (mid_item),
        .o_item_pop   (mid_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_edge0      (o_edge0),
        .o_edge1      (o_edge1),
        .o_edge2      (o_edge2),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col)
    );

endmodule

`default_nettype wire

[sv/wmf_fifo.sv]
// Small synchronous queue with occupancy count, register storage.
// Standalone; used between front and back and as the result queue.
`default_nettype none

module wmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[sv/wmf_front.sv]
// Front end: width register, raster position counters, tags each request.
// Depends on wmf_pkg.
`default_nettype none

module wmf_front #(
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [wmf_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                     i_accept,
    input  wire logic                     i_sof,
    input  wire wmf_pkg::t_pix            i_pix,
    output logic [wmf_pkg::PIX_W+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] o_item
);

    import wmf_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CMP_W = (CFG_W > COL_W + 1) ? CFG_W + 1 : COL_W + 2;

    logic [CFG_W-1:0] r_frame_width;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [CMP_W-1:0] width_use;
    logic [CMP_W-1:0] col_inc;
    logic [ROW_W:0]   row_inc;

    // Clamp the programmed width to the usable range
    always_comb begin
        width_use = CMP_W'(r_frame_width);
        if (width_use < CMP_W'(KSIZE)) begin
            width_use = CMP_W'(KSIZE);
        end else if (width_use > CMP_W'(MAX_WIDTH)) begin
            width_use = CMP_W'(MAX_WIDTH);
        end
    end

    // Position of this request; start of frame restarts at the origin
    assign cur_col = i_sof ? '0 : r_col;
    assign cur_row = i_sof ? '0 : r_row;
    assign o_item  = {i_pix, cur_row, cur_col};

    // Step to the next raster position
    always_comb begin
        col_inc = CMP_W'(cur_col) + CMP_W'(1);
        row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);
        n_col   = col_inc[COL_W-1:0];
        n_row   = cur_row;
        if (col_inc >= width_use) begin
            n_col = '0;
            n_row = (row_inc >= (ROW_W+1)'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RST;
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_width <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

`ifndef SYNTH
    // A start-of-frame request leaves the counters at row zero, column one
    a_sof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_sof |=> r_row == '0 && r_col == COL_W'(1))
        else $error("front: counters not restarted by start of frame");
`endif

endmodule

`default_nettype wire

[sv/wmf_back.sv]
// Back end: line store memory, 3x3 window, per-channel max/min and result queue.
// Depends on wmf_pkg and wmf_fifo.
`default_nettype none

module wmf_back #(
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_item_valid,
    input  wire logic [wmf_pkg::PIX_W+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] i_item,
    output logic                             o_item_pop,
    input  wire logic                        i_pop,
    output logic                             o_empty,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge0,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge1,
    output logic [wmf_pkg::CHAN_W-1:0]       o_edge2,
    output logic [$clog2(MAX_HEIGHT)-1:0]    o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_out_col
);

    import wmf_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int OUT_W  = PIX_W + ROW_W + COL_W;
    localparam int OCNT_W = $clog2(OUT_DEPTH+1);
    localparam int CRD_W  = OCNT_W + 1;
    localparam int WORD_W = 2 * PIX_W;

    // Unpack the popped request
    t_pix             item_pix;
    logic [ROW_W-1:0] item_row;
    logic [COL_W-1:0] item_col;
    assign {item_pix, item_row, item_col} = i_item;

    // Line store: upper half is the row above, lower half two rows above
    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd;

    // Compute stage
    logic              r_v1;
    t_pix              r_pix1;
    logic [ROW_W-1:0]  r_row1;
    logic [COL_W-1:0]  r_col1;
    logic              r_fwd;
    logic [WORD_W-1:0] r_fwd_word;
    t_pix              r_win [6];

    // Result stage
    logic              r_v2;
    logic              r_emit2;
    logic [CHAN_W-1:0] r_hi [N_CHAN];
    logic [CHAN_W-1:0] r_lo [N_CHAN];
    logic [ROW_W-1:0]  r_row2;
    logic [COL_W-1:0]  r_col2;

    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] wdata;
    t_pix              above1;
    t_pix              above2;
    t_pix              top1;
    t_pix              mid1;
    t_pix              win9 [9];
    logic [CHAN_W-1:0] hi1 [N_CHAN];
    logic [CHAN_W-1:0] lo1 [N_CHAN];
    logic              emit1;

    logic [OUT_W-1:0]  out_data;
    logic [OUT_W-1:0]  out_head;
    logic              out_push;
    logic [OCNT_W-1:0] out_cnt;
    logic [CRD_W-1:0]  in_use;
    logic [CHAN_W-1:0] edge_res [N_CHAN];

    // Pop only when the result queue has room for everything in flight
    assign in_use     = CRD_W'(out_cnt) + CRD_W'(r_v1) + CRD_W'(r_v2);
    assign o_item_pop = i_item_valid && (in_use < CRD_W'(OUT_DEPTH));

    // Read at pop, write back from the compute stage (read returns old data)
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_mem[r_col1] <= wdata;
        end
        if (o_item_pop) begin
            r_rd <= r_mem[item_col];
        end
    end

    // Line store word seen by the compute stage, bypassing a same-column write
    assign word1  = r_fwd ? r_fwd_word : r_rd;
    assign above1 = word1[WORD_W-1:PIX_W];
    assign above2 = word1[PIX_W-1:0];
    assign wdata  = {r_pix1, above1};

    // Mask rows above the image
    assign mid1  = (r_row1 != '0) ? above1 : '0;
    assign top1  = (r_row1 > ROW_W'(1)) ? above2 : '0;
    assign emit1 = (r_row1 != '0) && (r_col1 != '0);

    // Assemble the window; left columns clear at column zero
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            win9[k] = (r_col1 == '0) ? '0 : r_win[k];
        end
        win9[6] = top1;
        win9[7] = mid1;
        win9[8] = r_pix1;
    end

    // Per-channel maximum and minimum over the nine taps
    always_comb begin
        for (int c = 0; c < N_CHAN; c++) begin
            hi1[c] = win9[0][c*CHAN_W +: CHAN_W];
            lo1[c] = win9[0][c*CHAN_W +: CHAN_W];
            for (int k = 1; k < 9; k++) begin
                if (win9[k][c*CHAN_W +: CHAN_W] > hi1[c]) begin
                    hi1[c] = win9[k][c*CHAN_W +: CHAN_W];
                end
                if (win9[k][c*CHAN_W +: CHAN_W] < lo1[c]) begin
                    lo1[c] = win9[k][c*CHAN_W +: CHAN_W];
                end
            end
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
            r_v2  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_v1  <= o_item_pop;
            r_fwd <= o_item_pop && r_v1 && (r_col1 == item_col);
            r_v2  <= r_v1;
            // Shift the window one column
            if (r_v1) begin
                r_win[0] <= win9[3];
                r_win[1] <= win9[4];
                r_win[2] <= win9[5];
                r_win[3] <= top1;
                r_win[4] <= mid1;
                r_win[5] <= r_pix1;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_pix1     <= item_pix;
            r_row1     <= item_row;
            r_col1     <= item_col;
            r_fwd_word <= wdata;
        end
        if (r_v1) begin
            r_emit2 <= emit1;
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            for (int c = 0; c < N_CHAN; c++) begin
                r_hi[c] <= hi1[c];
                r_lo[c] <= lo1[c];
            end
        end
    end

    // Finish the difference and queue the result for the centre pixel
    always_comb begin
        for (int c = 0; c < N_CHAN; c++) begin
            edge_res[c] = r_hi[c] - r_lo[c];
        end
    end

    assign out_push = r_v2 && r_emit2;
    assign out_data = {edge_res[2], edge_res[1], edge_res[0],
                       r_row2 - ROW_W'(1), r_col2 - COL_W'(1)};

    wmf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .i_pop   (i_pop),
        .o_data  (out_head),
        .o_full  (),
        .o_empty (o_empty),
        .o_count (out_cnt)
    );

    assign {o_edge2, o_edge1, o_edge0, o_out_row, o_out_col} = out_head;

`ifndef SYNTH
    // The credit check keeps the result queue from overflowing
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> out_cnt < OCNT_W'(OUT_DEPTH))
        else $error("back: result queue written while full");

    // In-flight work never exceeds the result queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_use <= CRD_W'(OUT_DEPTH))
        else $error("back: credit count exceeded");

    // Bypass only follows a back-to-back request at the same column
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v1 && $past(r_v1) && r_col1 == $past(r_col1))
        else $error("back: line store bypass without matching write");
`endif

endmodule

`default_nettype wire
